/* hdl/vbwp_pkg.sv */
// shared types and constants for the voxel work partition unit
package vbwp_pkg;

    localparam int unsigned MaxExtentDef  = 1024;
    localparam int unsigned MaxWorkersDef = 64;

    localparam int unsigned CoordW = 10;
    localparam int unsigned CntW   = 7;
    localparam int unsigned CountW = 31;
    localparam int unsigned IdxW   = 3;

    // register indexes
    localparam logic [IdxW-1:0] RegXLow   = 3'd0;
    localparam logic [IdxW-1:0] RegXHigh  = 3'd1;
    localparam logic [IdxW-1:0] RegYLow   = 3'd2;
    localparam logic [IdxW-1:0] RegYHigh  = 3'd3;
    localparam logic [IdxW-1:0] RegZLow   = 3'd4;
    localparam logic [IdxW-1:0] RegZHigh  = 3'd5;
    localparam logic [IdxW-1:0] RegWorkers = 3'd6;

    // job kind decided by the front end
    typedef enum logic [1:0] {
        JOB_WORKER = 2'd0,
        JOB_HOST   = 2'd1,
        JOB_NONE   = 2'd2
    } t_job_kind;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_DIVA = 4'b0010,
        ST_DIVB = 4'b0100,
        ST_DIVC = 4'b1000
    } t_be_state;

endpackage

/* hdl/voxel_bundle_work_partition_unit.sv */
// top level of the voxel bundle work partition unit
//  channel  | direction | handshake      | payload
//  config   | in        | i_cfg_we       | i_cfg_index, i_cfg_data
//  request  | in        | push / full    | i_job_index
//  result   | out       | empty / pop    | o_start_x/y/z, o_voxel_count
// a request passes the front pipeline to the front tail, then the front bit-serial divide over
// PW = 3*EW+JW+1 numerator bits, and then the two back divides and the result write
// the back decode takes no new request until it has written the last result
// reset is synchronous, active low, and clears all handshake state
// full rises while the front tail holds an untaken item; empty while no result waits
module voxel_bundle_work_partition_unit #(
    parameter int unsigned MAX_EXTENT  = vbwp_pkg::MaxExtentDef,
    parameter int unsigned MAX_WORKERS = vbwp_pkg::MaxWorkersDef
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [vbwp_pkg::IdxW-1:0]   i_cfg_index,
    input  logic [vbwp_pkg::CoordW-1:0] i_cfg_data,
    input  logic                        push,
    output logic                        full,
    input  logic [vbwp_pkg::CntW-1:0]   i_job_index,
    output logic                        empty,
    input  logic                        pop,
    output logic [vbwp_pkg::CoordW-1:0] o_start_x,
    output logic [vbwp_pkg::CoordW-1:0] o_start_y,
    output logic [vbwp_pkg::CoordW-1:0] o_start_z,
    output logic [vbwp_pkg::CountW-1:0] o_voxel_count
);
    import vbwp_pkg::*;

    localparam int unsigned EW = $clog2(MAX_EXTENT + 1);
    localparam int unsigned TW = 3 * EW;

    logic [CoordW-1:0] r_x_low, r_x_high, r_y_low, r_y_high, r_z_low, r_z_high;
    logic [CntW-1:0]   r_workers;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_low <= '0; r_x_high <= '0; r_y_low <= '0; r_y_high <= '0;
            r_z_low <= '0; r_z_high <= '0; r_workers <= CntW'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                RegXLow:    r_x_low  <= i_cfg_data;
                RegXHigh:   r_x_high <= i_cfg_data;
                RegYLow:    r_y_low  <= i_cfg_data;
                RegYHigh:   r_y_high <= i_cfg_data;
                RegZLow:    r_z_low  <= i_cfg_data;
                RegZHigh:   r_z_high <= i_cfg_data;
                RegWorkers: r_workers <= i_cfg_data[CntW-1:0];
                default: ;
            endcase
        end
    end

    logic          f_valid, f_take;
    logic [TW-1:0] f_start, f_count;
    logic [EW-1:0] f_nx, f_ny;

    vbwp_front #(.MAX_EXTENT(MAX_EXTENT), .MAX_WORKERS(MAX_WORKERS), .EW(EW), .TW(TW))
    u_front (
        .i_clk, .i_rst_n,
        .i_x_low(r_x_low), .i_x_high(r_x_high), .i_y_low(r_y_low),
        .i_y_high(r_y_high), .i_z_low(r_z_low), .i_z_high(r_z_high),
        .i_worker_count(r_workers),
        .i_push(push && !full), .i_job_index, .o_full(full),
        .o_valid(f_valid), .i_take(f_take),
        .o_start(f_start), .o_count(f_count), .o_nx(f_nx), .o_ny(f_ny)
    );

    vbwp_back #(.EW(EW), .TW(TW)) u_back (
        .i_clk, .i_rst_n,
        .i_valid(f_valid), .o_take(f_take),
        .i_start(f_start), .i_count(f_count), .i_nx(f_nx), .i_ny(f_ny),
        .i_x_low(r_x_low), .i_y_low(r_y_low), .i_z_low(r_z_low),
        .i_pop(pop), .o_empty(empty),
        .o_start_x, .o_start_y, .o_start_z, .o_voxel_count
    );
endmodule

/* hdl/vbwp_front.sv */
// front end: extents, job classification and share boundaries
module vbwp_front #(
    parameter int unsigned MAX_EXTENT  = vbwp_pkg::MaxExtentDef,
    parameter int unsigned MAX_WORKERS = vbwp_pkg::MaxWorkersDef,
    parameter int unsigned EW = $clog2(MAX_EXTENT + 1),
    parameter int unsigned TW = 3 * EW
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [vbwp_pkg::CoordW-1:0] i_x_low,
    input  logic [vbwp_pkg::CoordW-1:0] i_x_high,
    input  logic [vbwp_pkg::CoordW-1:0] i_y_low,
    input  logic [vbwp_pkg::CoordW-1:0] i_y_high,
    input  logic [vbwp_pkg::CoordW-1:0] i_z_low,
    input  logic [vbwp_pkg::CoordW-1:0] i_z_high,
    input  logic [vbwp_pkg::CntW-1:0]   i_worker_count,
    input  logic                        i_push,
    input  logic [vbwp_pkg::CntW-1:0]   i_job_index,
    output logic                        o_full,
    output logic                        o_valid,
    input  logic                        i_take,
    output logic [TW-1:0]               o_start,
    output logic [TW-1:0]               o_count,
    output logic [EW-1:0]               o_nx,
    output logic [EW-1:0]               o_ny
);
    import vbwp_pkg::*;

    localparam int unsigned JW = $clog2(MAX_WORKERS + 2);

    function automatic logic [EW-1:0] extent(input logic [CoordW-1:0] lo,
                                             input logic [CoordW-1:0] hi);
        logic [CoordW:0] e;
        begin
            e = {1'b0, hi} - {1'b0, lo} + 1'b1;
            if (hi < lo) return '0;
            if (32'(e) > MAX_EXTENT) return EW'(MAX_EXTENT);
            return EW'(e);
        end
    endfunction

    logic [EW-1:0] nx, ny, nz;
    logic [CntW:0] jobs_c;
    logic [JW-1:0] jobs;
    assign nx = extent(i_x_low, i_x_high);
    assign ny = extent(i_y_low, i_y_high);
    assign nz = extent(i_z_low, i_z_high);
    always_comb begin
        jobs_c = {1'b0, i_worker_count};
        if (jobs_c == '0) jobs_c = (CntW+1)'(1);
        if (32'(jobs_c) > MAX_WORKERS) jobs_c = (CntW+1)'(MAX_WORKERS);
    end
    assign jobs = JW'(jobs_c);

    // stage 1: product nx*ny and classify
    logic          r_v1, r_v2, r_v3, r_v4;
    logic [2*EW-1:0] r_nxy;
    logic [EW-1:0] r_nz, r_nx1, r_ny1;
    logic [JW-1:0] r_job1, r_jobs1;
    t_job_kind     r_kind1, n_kind;
    logic          adv1, adv2, adv3, adv4;

    always_comb begin
        if ({1'b0, i_job_index} == (CntW+1)'(jobs)) n_kind = JOB_HOST;
        else if ({1'b0, i_job_index} < (CntW+1)'(jobs)) n_kind = JOB_WORKER;
        else n_kind = JOB_NONE;
    end

    // pipeline moves as a whole when the tail is free
    assign adv4 = !r_v4 || i_take;
    assign adv3 = adv4;
    assign adv2 = adv4;
    assign adv1 = adv4;
    assign o_full = !adv4;

    always_ff @(posedge i_clk) begin
        if (adv1) begin
            r_nxy   <= (2*EW)'(nx) * (2*EW)'(ny);
            r_nz    <= nz;
            r_nx1   <= nx;
            r_ny1   <= ny;
            r_job1  <= JW'(i_job_index);
            r_jobs1 <= jobs;
            r_kind1 <= n_kind;
        end
    end

    // stage 2: total product
    logic [TW-1:0] r_total2;
    logic [EW-1:0] r_nx2, r_ny2;
    logic [JW-1:0] r_job2, r_jobs2;
    t_job_kind     r_kind2;
    always_ff @(posedge i_clk) begin
        if (adv2) begin
            r_total2 <= TW'(r_nxy * (TW-EW)'(0) + r_nxy) * TW'(r_nz);
            r_nx2 <= r_nx1; r_ny2 <= r_ny1;
            r_job2 <= r_job1; r_jobs2 <= r_jobs1; r_kind2 <= r_kind1;
        end
    end

    // stage 3: numerators for both edges
    localparam int unsigned PW = TW + JW + 1;
    logic [PW-1:0] r_na, r_nb;
    logic [TW-1:0] r_total3;
    logic [EW-1:0] r_nx3, r_ny3;
    logic [JW-1:0] r_jobs3;
    t_job_kind     r_kind3;
    logic [TW-3:0] bundles;
    assign bundles = r_total2[TW-1:2];
    always_ff @(posedge i_clk) begin
        if (adv3) begin
            r_na <= ((PW'(bundles) * PW'(r_job2)) << 1) + PW'(r_jobs2);
            r_nb <= ((PW'(bundles) * (PW'(r_job2) + 1'b1)) << 1) + PW'(r_jobs2);
            r_total3 <= r_total2;
            r_nx3 <= r_nx2; r_ny3 <= r_ny2; r_jobs3 <= r_jobs2; r_kind3 <= r_kind2;
        end
    end

    // stage 4: hold the operands while the share edges are divided by 2*jobs
    logic [PW-1:0] r_na4, r_nb4;
    logic [TW-1:0] r_total4;
    logic [EW-1:0] r_nx4, r_ny4;
    logic [JW-1:0] r_jobs4;
    t_job_kind     r_kind4;
    always_ff @(posedge i_clk) begin
        if (adv4) begin
            r_na4 <= r_na; r_nb4 <= r_nb; r_total4 <= r_total3;
            r_nx4 <= r_nx3; r_ny4 <= r_ny3; r_jobs4 <= r_jobs3; r_kind4 <= r_kind3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0; r_v2 <= 1'b0; r_v3 <= 1'b0; r_v4 <= 1'b0;
        end else if (adv4) begin
            r_v1 <= i_push; r_v2 <= r_v1; r_v3 <= r_v2; r_v4 <= r_v3;
        end
    end

    // share edges: divide both numerators by 2*jobs, bit-serial per entry
    logic [PW-1:0] r_qa, r_qb, r_ra, r_rb;
    logic [$clog2(PW+1)-1:0] r_bit;
    logic r_busy, r_done;
    logic [JW:0] dv;
    logic [PW:0] ta, tb;
    assign dv = {r_jobs4, 1'b0};
    assign ta = {r_ra, r_na4[PW-1 - r_bit[$clog2(PW)-1:0]]};
    assign tb = {r_rb, r_nb4[PW-1 - r_bit[$clog2(PW)-1:0]]};
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0; r_done <= 1'b0; r_bit <= '0;
        end else if (r_v4 && !r_busy && !r_done) begin
            r_busy <= 1'b1; r_bit <= '0; r_qa <= '0; r_qb <= '0; r_ra <= '0; r_rb <= '0;
        end else if (r_busy) begin
            r_ra <= (ta >= (PW+1)'(dv)) ? PW'(ta - (PW+1)'(dv)) : PW'(ta);
            r_rb <= (tb >= (PW+1)'(dv)) ? PW'(tb - (PW+1)'(dv)) : PW'(tb);
            r_qa <= {r_qa[PW-2:0], ta >= (PW+1)'(dv)};
            r_qb <= {r_qb[PW-2:0], tb >= (PW+1)'(dv)};
            r_bit <= r_bit + 1'b1;
            if (32'(r_bit) == PW-1) begin
                r_busy <= 1'b0; r_done <= 1'b1;
            end
        end else if (r_done && i_take) begin
            r_done <= 1'b0;
        end
    end

    assign o_valid = r_done;
    always_comb begin
        o_start = '0;
        o_count = '0;
        case (r_kind4)
            JOB_HOST: begin
                o_count = TW'(r_total4[1:0]);
                o_start = r_total4 - o_count;
            end
            JOB_WORKER: begin
                o_start = TW'(r_qa << 2);
                o_count = TW'((r_qb - r_qa) << 2);
            end
            default: ;
        endcase
    end
    assign o_nx = r_nx4;
    assign o_ny = r_ny4;

    // the tail only frees once a finished result is taken
    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_busy |-> !r_done)
        else $error("front divider busy and done together");
    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_done |-> r_v4)
        else $error("front result without held item");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v4 && !i_take) |=> r_v4)
        else $error("front tail item lost");
endmodule

/* hdl/vbwp_back.sv */
// back end: start offset decode into coordinates and result queue
module vbwp_back #(
    parameter int unsigned EW = 11,
    parameter int unsigned TW = 33
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_take,
    input  logic [TW-1:0]               i_start,
    input  logic [TW-1:0]               i_count,
    input  logic [EW-1:0]               i_nx,
    input  logic [EW-1:0]               i_ny,
    input  logic [vbwp_pkg::CoordW-1:0] i_x_low,
    input  logic [vbwp_pkg::CoordW-1:0] i_y_low,
    input  logic [vbwp_pkg::CoordW-1:0] i_z_low,
    input  logic                        i_pop,
    output logic                        o_empty,
    output logic [vbwp_pkg::CoordW-1:0] o_start_x,
    output logic [vbwp_pkg::CoordW-1:0] o_start_y,
    output logic [vbwp_pkg::CoordW-1:0] o_start_z,
    output logic [vbwp_pkg::CountW-1:0] o_voxel_count
);
    import vbwp_pkg::*;

    localparam int unsigned CW = $clog2(TW + 1);

    t_be_state r_st;
    logic [TW-1:0] r_num, r_q, r_rem, r_cnt;
    logic [EW-1:0] r_nx, r_ny, r_div, r_px;
    logic [CW-1:0] r_bit;
    logic [TW:0]   t;
    logic          ge;
    logic          r_ov;

    assign t  = {r_rem, r_num[TW-1 - r_bit]};
    assign ge = (r_div != '0) && (t >= (TW+1)'(r_div));

    assign o_take = (r_st == ST_IDLE) && i_valid && (!r_ov || i_pop);
    assign o_empty = !r_ov;

    // two serial divisions, by nx then by ny, then the result write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_IDLE; r_ov <= 1'b0;
        end else begin
            if (i_pop && r_ov && r_st != ST_DIVC) r_ov <= 1'b0;
            case (r_st)
                ST_IDLE: begin
                    if (o_take) begin
                        r_num <= i_start; r_cnt <= i_count;
                        r_nx <= i_nx; r_ny <= i_ny; r_div <= i_nx;
                        r_q <= '0; r_rem <= '0; r_bit <= '0;
                        r_st <= ST_DIVA;
                    end
                end
                ST_DIVA, ST_DIVB: begin
                    if (32'(r_bit) == TW-1 && r_st == ST_DIVA) begin
                        r_px <= (r_nx == '0) ? '0 : EW'(ge ? t - (TW+1)'(r_div) : t);
                        r_num <= {r_q[TW-2:0], ge};
                        r_div <= r_ny; r_q <= '0; r_rem <= '0; r_bit <= '0;
                        r_st <= ST_DIVB;
                    end else begin
                        r_rem <= ge ? TW'(t - (TW+1)'(r_div)) : TW'(t);
                        r_q <= {r_q[TW-2:0], ge};
                        r_bit <= r_bit + 1'b1;
                        if (32'(r_bit) == TW-1) r_st <= ST_DIVC;
                    end
                end
                ST_DIVC: begin
                    if (!r_ov || i_pop) begin
                        o_start_x <= CoordW'(r_px) + i_x_low;
                        o_start_y <= ((r_ny == '0) ? CoordW'(r_num) : CoordW'(r_rem)) + i_y_low;
                        o_start_z <= CoordW'(r_q) + i_z_low;
                        o_voxel_count <= CountW'(r_cnt);
                        r_ov <= 1'b1;
                        r_st <= ST_IDLE;
                    end
                end
                default: r_st <= ST_IDLE;
            endcase
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n) $onehot(r_st))
        else $error("back state not one-hot");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == ST_DIVC && (!r_ov || i_pop)) |=> r_ov)
        else $error("back result not queued");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !i_pop) |=> (r_ov && $stable(o_voxel_count)))
        else $error("back result changed while waiting");
endmodule
